[sv/erd_pkg.sv]
`default_nettype none
package erd_pkg;

    localparam int RECORD_COUNT_BITS = 24;
    localparam int TABLE_SIZE_BITS   = 32;

    // Configuration register indexes
    localparam logic [2:0] REG_FORMAT  = 3'd0;
    localparam logic [2:0] REG_ARCH    = 3'd1;
    localparam logic [2:0] REG_ESIZE   = 3'd2;
    localparam logic [2:0] REG_BASE    = 3'd3;
    localparam logic [2:0] REG_TBYTES  = 3'd4;
    localparam logic [2:0] REG_MAXREC  = 3'd5;
    localparam logic [2:0] REG_SECTION = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_SIZE     = 2'd1;
    localparam logic [1:0] ERR_LIMIT    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Relocation kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_ABS32   = 3'd1;
    localparam logic [2:0] KIND_ABS64   = 3'd2;
    localparam logic [2:0] KIND_PCREL32 = 3'd3;
    localparam logic [2:0] KIND_REL32   = 3'd4;
    localparam logic [2:0] KIND_REL64   = 3'd5;
    localparam logic [2:0] KIND_GOT     = 3'd6;

    // Architectures
    localparam logic [2:0] ARCH_X86     = 3'd0;
    localparam logic [2:0] ARCH_X86_64  = 3'd1;
    localparam logic [2:0] ARCH_ARM     = 3'd2;
    localparam logic [2:0] ARCH_ARM64   = 3'd3;
    localparam logic [2:0] ARCH_RV32    = 3'd4;
    localparam logic [2:0] ARCH_RV64    = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV
    } t_front_state;

    // Completed entry handed from the front to the back
    typedef struct packed {
        logic                       is_err;
        logic [1:0]                 err_code;
        logic [TABLE_SIZE_BITS-1:0] entry_start;
        logic [63:0]                offset;
        logic [63:0]                info;
        logic [63:0]                addend;
        logic                       wide;
        logic                       expl;
    } t_entry;

    // Result item
    typedef struct packed {
        logic [31:0]                  error_offset;
        logic [1:0]                   error_code;
        logic [15:0]                  section_number;
        logic [3:0]                   patch_width;
        logic [63:0]                  addend_value;
        logic [63:0]                  target_address;
        logic [31:0]                  symbol_number;
        logic [2:0]                   reloc_kind;
        logic [RECORD_COUNT_BITS-1:0] record_index;
    } t_result;

    function automatic logic [2:0] kind_of(input logic [2:0] arch, input logic [31:0] ty);
        logic [2:0] k;
        k = KIND_NONE;
        case (arch)
            ARCH_X86: begin
                if (ty == 32'd1) k = KIND_ABS32;
                else if (ty == 32'd2) k = KIND_PCREL32;
                else if (ty == 32'd8) k = KIND_REL32;
            end
            ARCH_X86_64: begin
                if (ty == 32'd1) k = KIND_ABS64;
                else if (ty == 32'd2) k = KIND_PCREL32;
                else if (ty == 32'd8) k = KIND_REL64;
                else if (ty == 32'd9) k = KIND_GOT;
            end
            ARCH_ARM: begin
                if (ty == 32'd2) k = KIND_ABS32;
                else if (ty == 32'd3) k = KIND_PCREL32;
                else if (ty == 32'd23) k = KIND_REL32;
            end
            ARCH_ARM64: begin
                if (ty == 32'd257) k = KIND_ABS64;
                else if (ty == 32'd260) k = KIND_PCREL32;
                else if (ty == 32'd1027) k = KIND_REL64;
            end
            ARCH_RV32, ARCH_RV64: begin
                if (ty == 32'd1) k = KIND_ABS32;
                else if (ty == 32'd2) k = KIND_ABS64;
                else if (ty == 32'd3) k = KIND_REL64;
            end
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

[sv/elf_relocation_decoder_top.sv]
`default_nettype none
// ELF relocation table decoder. Table bytes arrive one per transfer on the slave stream
// (tuser marks a table's first byte) and at most one result leaves per completed entry.
// Bytes are taken one per cycle while the queue has room; after a table opens, tready
// stays low while a shift-subtract divider checks that the entry size divides the table
// length, and longer until earlier entries have left the queue. A two-entry queue parts
// byte assembly from result formation, and the output register holds a result while the
// next bytes are still taken. Configuration must be written only while idle (unchecked).
module elf_relocation_decoder_top import erd_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // data_byte
    input  wire logic          s_axis_tuser,   // table_start
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // record_index[23:0] reloc_kind[26:24] symbol_number[58:27] target_address[122:59]
    // addend_value[186:123] patch_width[190:187] section_number[206:191]
    // error_code[208:207] error_offset[240:209], zero fill to 248
    output logic [247:0]       m_axis_tdata,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data
);

    logic [2:0]  r_format, r_arch;
    logic [7:0]  r_esize;
    logic [63:0] r_base;
    logic [TABLE_SIZE_BITS-1:0]   r_tbytes;
    logic [RECORD_COUNT_BITS-1:0] r_maxrec;
    logic [15:0] r_section;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= '0; r_arch <= '0; r_esize <= '0; r_base <= '0;
            r_tbytes <= TABLE_SIZE_BITS'(1); r_maxrec <= '1; r_section <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FORMAT:  r_format  <= i_cfg_data[2:0];
                REG_ARCH:    r_arch    <= i_cfg_data[2:0];
                REG_ESIZE:   r_esize   <= i_cfg_data[7:0];
                REG_BASE:    r_base    <= i_cfg_data;
                REG_TBYTES:  r_tbytes  <= i_cfg_data[TABLE_SIZE_BITS-1:0];
                REG_MAXREC:  r_maxrec  <= i_cfg_data[RECORD_COUNT_BITS-1:0];
                REG_SECTION: r_section <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic    f_push, q_full, q_valid, q_pop, f_busy;
    logic    q_empty;
    t_entry  f_entry, q_entry;
    logic [RECORD_COUNT_BITS-1:0] b_records;
    t_result b_res;

    // The record count is exact once the queue has emptied
    assign q_empty = !q_valid;

    erd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_start(s_axis_tuser),
        .i_format(r_format), .i_entry_size(r_esize), .i_table_bytes(r_tbytes),
        .i_max_records(r_maxrec), .i_records_emitted(b_records), .i_q_empty(q_empty),
        .o_push(f_push), .o_entry(f_entry), .i_full(q_full), .o_busy(f_busy)
    );

    erd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_entry(f_entry), .o_full(q_full),
        .o_valid(q_valid), .o_entry(q_entry), .i_pop(q_pop)
    );

    erd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_entry(q_entry), .o_pop(q_pop),
        .i_arch(r_arch), .i_base(r_base), .i_max_records(r_maxrec),
        .i_section(r_section), .o_records(b_records),
        .o_valid(m_axis_tvalid), .o_result(b_res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, b_res};

    // No bytes taken while the size divider runs
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_busy |-> !s_axis_tready) else $error("byte taken during division");
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !f_push) else $error("queue overflow");
    // A waiting result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
`default_nettype wire

[sv/erd_front.sv]
`default_nettype none
module erd_front import erd_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [7:0]                 i_byte,
    input  wire logic                       i_start,
    input  wire logic [2:0]                 i_format,
    input  wire logic [7:0]                 i_entry_size,
    input  wire logic [TABLE_SIZE_BITS-1:0] i_table_bytes,
    input  wire logic [RECORD_COUNT_BITS-1:0] i_max_records,
    input  wire logic [RECORD_COUNT_BITS-1:0] i_records_emitted,
    input  wire logic                       i_q_empty,
    output logic                            o_push,
    output t_entry                          o_entry,
    input  wire logic                       i_full,
    output logic                            o_busy
);

    localparam int TB = TABLE_SIZE_BITS;
    localparam int CB = $clog2(TB + 1);

    t_front_state r_state, n_state;
    logic [TB-1:0] r_tpos, n_tpos;
    logic [7:0]    r_epos, n_epos;
    logic [TB-1:0] r_estart, n_estart;
    logic [63:0]   r_off, n_off, r_inf, n_inf, r_add, n_add;
    logic          r_open, n_open, r_fail, n_fail;
    // Restoring divider for entry count
    logic [TB-1:0] r_rem, n_rem, r_quo, n_quo;
    logic [7:0]    r_div, n_div;
    logic [CB-1:0] r_cnt, n_cnt;
    // Opening byte of a table, kept while the division runs
    logic [7:0]    r_byte, n_byte;

    logic       wide, expl, big;
    logic [4:0] min_sz;
    logic [7:0] eff;
    logic [4:0] w;
    logic       accept;

    assign wide   = i_format[0];
    assign expl   = i_format[1];
    assign big    = i_format[2];
    assign min_sz = expl ? (wide ? 5'd24 : 5'd12) : (wide ? 5'd16 : 5'd8);
    assign eff    = (i_entry_size != 8'd0) ? i_entry_size : {3'd0, min_sz};
    assign w      = wide ? 5'd8 : 5'd4;

    // Ready when queue has room and no division is running
    assign o_ready = (r_state == ST_RUN) && !i_full;
    assign accept  = i_valid && o_ready;
    assign o_busy  = (r_state != ST_RUN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: if (accept && i_start && !(({3'd0, min_sz} > eff)
                        || ({{(TB-8){1'b0}}, eff} > i_table_bytes))) n_state = ST_DIV;
            ST_DIV: if (r_cnt == CB'(0) && i_q_empty) n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        logic [TB:0]   trial;
        logic [8:0]    ep1;
        logic [8:0]    k;
        logic [1:0]    sel;
        logic [TB:0]   tp1;
        logic          emit;
        logic [TB:0]   left;
        logic          ep0;
        logic [63:0]   o0, i0, a0;
        n_tpos = r_tpos; n_epos = r_epos; n_estart = r_estart;
        n_off = r_off; n_inf = r_inf; n_add = r_add;
        n_open = r_open; n_fail = r_fail;
        n_rem = r_rem; n_quo = r_quo; n_div = r_div; n_cnt = r_cnt;
        n_byte = r_byte;
        o_push = 1'b0;
        o_entry = '0;
        o_entry.wide = wide;
        o_entry.expl = expl;
        trial = '0; ep1 = '0; k = '0; sel = 2'd3; tp1 = '0; emit = 1'b0;
        left = '0; ep0 = 1'b0; o0 = '0; i0 = '0; a0 = '0;
        case (r_state)
            ST_DIV: begin
                if (r_cnt != CB'(0)) begin
                    trial = {r_rem, r_quo[TB-1]} - {{(TB-7){1'b0}}, r_div};
                    if (!trial[TB]) begin
                        n_rem = trial[TB-1:0];
                        n_quo = {r_quo[TB-2:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[TB-2:0], r_quo[TB-1]};
                        n_quo = {r_quo[TB-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - CB'(1);
                end else if (i_q_empty) begin
                    // Quotient in r_quo, remainder in r_rem; record count is settled
                    left = (i_max_records > i_records_emitted)
                           ? (TB+1)'(i_max_records - i_records_emitted)
                           : '0;
                    if (r_rem != '0) begin
                        o_push = 1'b1; o_entry.is_err = 1'b1; o_entry.err_code = ERR_SIZE;
                        n_fail = 1'b1;
                    end else if ({1'b0, r_quo} > left) begin
                        o_push = 1'b1; o_entry.is_err = 1'b1; o_entry.err_code = ERR_LIMIT;
                        n_fail = 1'b1;
                    end else begin
                        // Opening byte goes into the low offset byte; in big-endian order later bytes shift it up
                        n_off = {56'd0, r_byte}; n_inf = '0; n_add = '0;
                        n_estart = '0; n_epos = 8'd1; n_tpos = TB'(1);
                    end
                end
            end
            default: begin
                if (accept) begin
                    if (i_start) begin
                        n_open = 1'b1; n_fail = 1'b0;
                        n_tpos = '0; n_epos = '0; n_estart = '0;
                        if (({3'd0, min_sz} > eff)
                            || ({{(TB-8){1'b0}}, eff} > i_table_bytes)) begin
                            o_push = 1'b1; o_entry.is_err = 1'b1;
                            o_entry.err_code = ERR_SIZE; n_fail = 1'b1;
                        end else begin
                            // First byte is held until the division finishes
                            n_rem = '0; n_quo = i_table_bytes; n_div = eff;
                            n_cnt = CB'(TB);
                            n_byte = i_byte;
                        end
                    end
                    if (!i_start && r_open && !r_fail) begin
                        ep0 = (r_epos == 8'd0);
                        o0 = ep0 ? 64'd0 : r_off;
                        i0 = ep0 ? 64'd0 : r_inf;
                        a0 = ep0 ? 64'd0 : r_add;
                        if (ep0) n_estart = r_tpos;
                        k = {1'b0, r_epos};
                        if (k < {4'd0, w}) sel = 2'd0;
                        else if (k < {3'd0, w, 1'b0}) begin sel = 2'd1; k = k - {4'd0, w}; end
                        else if (expl && k < ({4'd0, w} + {3'd0, w, 1'b0})) begin
                            sel = 2'd2; k = k - {3'd0, w, 1'b0};
                        end
                        n_off = o0; n_inf = i0; n_add = a0;
                        case (sel)
                            2'd0: n_off = big ? {o0[55:0], i_byte}
                                              : o0 | ({56'd0, i_byte} << {k[2:0], 3'd0});
                            2'd1: n_inf = big ? {i0[55:0], i_byte}
                                              : i0 | ({56'd0, i_byte} << {k[2:0], 3'd0});
                            2'd2: n_add = big ? {a0[55:0], i_byte}
                                              : a0 | ({56'd0, i_byte} << {k[2:0], 3'd0});
                            default: ;
                        endcase
                        ep1 = {1'b0, r_epos} + 9'd1;
                        emit = ep1 >= {1'b0, eff};
                        n_epos = emit ? 8'd0 : ep1[7:0];
                        tp1 = {1'b0, r_tpos} + (TB+1)'(1);
                        if (tp1 >= {1'b0, i_table_bytes} || tp1[TB-1:0] == '0) n_open = 1'b0;
                        n_tpos = tp1[TB-1:0];
                        if (emit) begin
                            o_push = 1'b1;
                            o_entry.entry_start = ep0 ? r_tpos : r_estart;
                            o_entry.offset = n_off;
                            o_entry.info = n_inf;
                            o_entry.addend = n_add;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_open <= 1'b0; r_fail <= 1'b0;
            r_tpos <= '0; r_epos <= '0; r_estart <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_open <= n_open; r_fail <= n_fail;
            r_tpos <= n_tpos; r_epos <= n_epos; r_estart <= n_estart;
            r_cnt <= n_cnt;
        end
        r_off <= n_off; r_inf <= n_inf; r_add <= n_add;
        r_rem <= n_rem; r_quo <= n_quo; r_div <= n_div;
        r_byte <= n_byte;
    end

endmodule
`default_nettype wire

[sv/erd_queue.sv]
`default_nettype none
module erd_queue import erd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_entry,
    input  wire logic   i_pop
);

    localparam int AB = $clog2(QUEUE_DEPTH);

    t_entry          r_mem [QUEUE_DEPTH];
    logic [AB-1:0]   r_wr, r_rd;
    logic [AB:0]     r_cnt;

    assign o_full  = (r_cnt == (AB+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    // Pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + AB'(1);
            if (i_pop) r_rd <= r_rd + AB'(1);
            r_cnt <= r_cnt + (AB+1)'(i_push) - (AB+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_entry;
    end

endmodule
`default_nettype wire

[sv/erd_back.sv]
`default_nettype none
module erd_back import erd_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  t_entry                            i_entry,
    output logic                              o_pop,
    input  wire logic [2:0]                   i_arch,
    input  wire logic [63:0]                  i_base,
    input  wire logic [RECORD_COUNT_BITS-1:0] i_max_records,
    input  wire logic [15:0]                  i_section,
    output logic [RECORD_COUNT_BITS-1:0]      o_records,
    output logic                              o_valid,
    output t_result                           o_result,
    input  wire logic                         i_ready
);

    logic [RECORD_COUNT_BITS-1:0] r_rec, n_rec;
    logic                         r_valid;
    t_result                      r_res, n_res;
    // Set after an entry error: later entries of the same table are discarded
    logic                         r_drop, n_drop;
    logic                         drop;

    assign o_records = r_rec;
    assign o_valid   = r_valid;
    assign o_result  = r_res;
    assign o_pop     = i_valid && (!r_valid || i_ready);

    // Turn one entry into a result
    always_comb begin
        logic [63:0] off, inf, add, tgt;
        logic        carry;
        logic [31:0] ty;
        logic [2:0]  kd;
        logic        fresh;
        off = i_entry.wide ? i_entry.offset : {32'd0, i_entry.offset[31:0]};
        inf = i_entry.wide ? i_entry.info : {32'd0, i_entry.info[31:0]};
        add = !i_entry.expl ? 64'd0 : i_entry.wide ? i_entry.addend
              : {{32{i_entry.addend[31]}}, i_entry.addend[31:0]};
        {carry, tgt} = {1'b0, i_base} + {1'b0, off};
        ty = i_entry.wide ? inf[31:0] : {24'd0, inf[7:0]};
        kd = kind_of(i_arch, ty);
        // A table error or an entry at offset zero opens a new table
        fresh = i_entry.is_err || (i_entry.entry_start == '0);
        drop = r_drop && !fresh;
        n_drop = 1'b0;
        n_res = '0;
        n_res.record_index = r_rec;
        n_rec = r_rec;
        if (drop) begin
            n_drop = 1'b1;
        end else if (i_entry.is_err) begin
            n_res.error_code = i_entry.err_code;
        end else if (carry) begin
            n_res.error_code = ERR_OVERFLOW;
            n_res.error_offset = i_entry.entry_start;
            n_drop = 1'b1;
        end else if (r_rec >= i_max_records) begin
            n_res.error_code = ERR_LIMIT;
            n_res.error_offset = i_entry.entry_start;
            n_drop = 1'b1;
        end else begin
            n_res.reloc_kind = kd;
            n_res.symbol_number = i_entry.wide ? inf[63:32] : {8'd0, inf[31:8]};
            n_res.target_address = tgt;
            n_res.addend_value = add;
            n_res.patch_width = (kd == KIND_ABS64 || kd == KIND_REL64) ? 4'd8 : 4'd4;
            n_res.section_number = i_section;
            n_rec = r_rec + RECORD_COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_rec <= '0; r_drop <= 1'b0;
        end else begin
            if (o_pop && !drop) begin
                r_valid <= 1'b1; r_rec <= n_rec;
            end else if (i_ready) r_valid <= 1'b0;
            if (o_pop) r_drop <= n_drop;
        end
        if (o_pop && !drop) r_res <= n_res;
    end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    import erd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // data_byte
    logic         s_axis_tuser;    // table_start
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [247:0] m_axis_tdata;    // result fields, record_index lowest
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    elf_relocation_decoder_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Decoder register copy
    logic [2:0]  fmt_q, arch_q;
    logic [7:0]  esize_q;
    logic [63:0] base_q;
    logic [31:0] tbytes_q;
    logic [23:0] maxrec_q;
    logic [15:0] section_q;

    // Decoder state copy
    logic [31:0] tab_pos, ent_start;
    logic [7:0]  ent_pos;
    logic [63:0] off_acc, info_acc, add_acc;
    logic [23:0] emitted;
    logic        failed, tab_open;

    t_result     reloc_q[$];
    int          errors;
    longint      cycles;
    int          n_results;
    int          n_sent;
    bit          sink_hold;

    function automatic logic [7:0] min_entry(input logic [2:0] f);
        return f[1] ? (f[0] ? 8'd24 : 8'd12) : (f[0] ? 8'd16 : 8'd8);
    endfunction

    function automatic logic [2:0] map_kind(input logic [2:0] a, input logic [31:0] t);
        case (a)
            ARCH_X86: return t == 1 ? KIND_ABS32 : t == 2 ? KIND_PCREL32 :
                             t == 8 ? KIND_REL32 : KIND_NONE;
            ARCH_X86_64: return t == 1 ? KIND_ABS64 : t == 2 ? KIND_PCREL32 :
                                t == 8 ? KIND_REL64 : t == 9 ? KIND_GOT : KIND_NONE;
            ARCH_ARM: return t == 2 ? KIND_ABS32 : t == 3 ? KIND_PCREL32 :
                             t == 23 ? KIND_REL32 : KIND_NONE;
            ARCH_ARM64: return t == 257 ? KIND_ABS64 : t == 260 ? KIND_PCREL32 :
                               t == 1027 ? KIND_REL64 : KIND_NONE;
            ARCH_RV32, ARCH_RV64: return t == 1 ? KIND_ABS32 : t == 2 ? KIND_ABS64 :
                                         t == 3 ? KIND_REL64 : KIND_NONE;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic t_result fail_result(input logic [1:0] code, input logic [31:0] at);
        t_result r;
        r = '0;
        r.record_index = emitted;
        r.error_code   = code;
        r.error_offset = at;
        failed = 1'b1;
        return r;
    endfunction

    function automatic void write_reg(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            REG_FORMAT:  fmt_q = v[2:0];
            REG_ARCH:    arch_q = v[2:0];
            REG_ESIZE:   esize_q = v[7:0];
            REG_BASE:    base_q = v;
            REG_TBYTES:  tbytes_q = v[31:0];
            REG_MAXREC:  maxrec_q = v[23:0];
            REG_SECTION: section_q = v[15:0];
            default: ;
        endcase
    endfunction

    // Decode one table byte; returns 1 with a result (relocation or error) when one is due
    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       output t_result r);
        logic [7:0]  eff, w, k;
        logic [63:0] info, off, add, target;
        logic [31:0] ty, sym;
        logic [23:0] left;
        logic [31:0] cnt;
        bit          emit;
        int          sel;
        eff = esize_q != 0 ? esize_q : min_entry(fmt_q);
        w = fmt_q[0] ? 8'd8 : 8'd4;
        r = '0;
        if (first) begin
            tab_open = 1; failed = 0; tab_pos = 0; ent_pos = 0; ent_start = 0;
            if (eff < min_entry(fmt_q) || eff > tbytes_q || tbytes_q % eff != 0) begin
                r = fail_result(ERR_SIZE, 32'd0);
                return 1;
            end
            cnt = tbytes_q / eff;
            left = maxrec_q > emitted ? maxrec_q - emitted : 24'd0;
            if (cnt > left) begin
                r = fail_result(ERR_LIMIT, 32'd0);
                return 1;
            end
        end
        if (!tab_open || failed) return 0;
        if (ent_pos == 0) begin
            off_acc = 0; info_acc = 0; add_acc = 0; ent_start = tab_pos;
        end
        k = ent_pos;
        sel = 0;
        if (k < w) sel = 1;
        else if (k < 2 * w) begin sel = 2; k = k - w; end
        else if (fmt_q[1] && k < 3 * w) begin sel = 3; k = k - 2 * w; end
        case (sel)
            1: off_acc = fmt_q[2] ? {off_acc[55:0], b} : off_acc | (64'(b) << (8 * k));
            2: info_acc = fmt_q[2] ? {info_acc[55:0], b} : info_acc | (64'(b) << (8 * k));
            3: add_acc = fmt_q[2] ? {add_acc[55:0], b} : add_acc | (64'(b) << (8 * k));
            default: ;
        endcase
        emit = 32'(ent_pos) + 1 >= 32'(eff);
        ent_pos = emit ? 8'd0 : ent_pos + 8'd1;
        if (33'(tab_pos) + 1 >= 33'(tbytes_q) || tab_pos == 32'hFFFF_FFFF) tab_open = 0;
        tab_pos = tab_pos + 1;
        if (!emit) return 0;
        info = fmt_q[0] ? info_acc : {32'd0, info_acc[31:0]};
        off  = fmt_q[0] ? off_acc : {32'd0, off_acc[31:0]};
        if (!fmt_q[1]) add = 0;
        else if (!fmt_q[0]) add = {{32{add_acc[31]}}, add_acc[31:0]};
        else add = add_acc;
        sym = fmt_q[0] ? info[63:32] : info[39:8];
        ty  = fmt_q[0] ? info[31:0] : {24'd0, info[7:0]};
        target = base_q + off;
        if (target < base_q) begin
            r = fail_result(ERR_OVERFLOW, ent_start);
            return 1;
        end
        if (emitted >= maxrec_q) begin
            r = fail_result(ERR_LIMIT, ent_start);
            return 1;
        end
        r.record_index   = emitted;
        r.reloc_kind     = map_kind(arch_q, ty);
        r.symbol_number  = sym;
        r.target_address = target;
        r.addend_value   = add;
        r.patch_width    = (r.reloc_kind == KIND_ABS64 || r.reloc_kind == KIND_REL64) ?
                           4'd8 : 4'd4;
        r.section_number = section_q;
        emitted = emitted + 1;
        return 1;
    endfunction

    // Drive one configuration transfer
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drive one byte transfer, with a random gap before it; predicts on acceptance
    task automatic send_byte(input logic [7:0] b, input logic first);
        t_result r;
        int      gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        if (decode_byte(b, first, r)) reloc_q = {reloc_q, r};
        @(negedge i_clk);
    endtask

    task automatic drain;
        int n;
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (reloc_q.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (60) @(negedge i_clk);
    endtask

    // One table of random content in the current format, cut off at random unless well formed
    task automatic send_table(input int nent, input bit well_formed);
        int eff, total;
        logic [63:0] word;
        eff = esize_q != 0 ? esize_q : min_entry(fmt_q);
        total = eff * nent;
        for (int i = 0; i < total; i++) begin
            word = {$urandom, $urandom};
            // favour small values, such as known relocation types, in every byte
            if ($urandom_range(0, 2) != 0) word[7:0] = 8'($urandom_range(0, 10));
            send_byte(word[7:0], i == 0);
            if (!well_formed && $urandom_range(0, 40) == 0) break;
        end
    endtask

    // Result checking at the rising edge
    always @(posedge i_clk) begin
        t_result got, exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[240:0]);
            if (reloc_q.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, got);
                errors++;
            end else begin
                exp_r = reloc_q.pop_front();
                n_results++;
                if (got !== exp_r || m_axis_tdata[247:241] !== 7'd0) begin
                    $display("%0t mismatch: expected %h actual %h", $realtime, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls at random, with one long hold-off
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                sink_hold = 0;
            end
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycles > 3000000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    typedef struct {
        logic [7:0] b;
        logic       first;
        bit         typed;
        t_result    want;
    } t_row;

    initial begin
        t_row rows[$];
        t_row row;
        t_result r;
        errors = 0; cycles = 0; n_results = 0; n_sent = 0; sink_hold = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        write_reg(REG_FORMAT, 0); write_reg(REG_ARCH, 0); write_reg(REG_ESIZE, 0);
        write_reg(REG_BASE, 0); write_reg(REG_TBYTES, 1);
        write_reg(REG_MAXREC, 24'hFF_FFFF); write_reg(REG_SECTION, 0);
        tab_pos = 0; ent_pos = 0; ent_start = 0; off_acc = 0; info_acc = 0;
        add_acc = 0; emitted = 0; failed = 0; tab_open = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset table length 1 is a bad entry size; stray bytes ignored
        r = '0; r.error_code = ERR_SIZE;
        row = '{8'h00, 1'b0, 1'b0, '0};
        rows = {rows, row};
        row = '{8'hFF, 1'b1, 1'b1, r};
        rows = {rows, row};
        row = '{8'hA5, 1'b0, 1'b0, '0};
        rows = {rows, row};
        foreach (rows[i]) begin
            send_byte(rows[i].b, rows[i].first);
            if (rows[i].typed && reloc_q.size() != 0 && reloc_q[$] !== rows[i].want) begin
                $display("%0t table row %0d: expected %h predicted %h", $realtime, i,
                         rows[i].want, reloc_q[$]);
                errors++;
            end
        end
        drain();

        // Directed: base overflow on an all-ones 32-bit entry, then x86 kinds
        cfg_write(REG_TBYTES, 8);
        cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_SECTION, 16'hFFFF);
        for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 0);
        drain();
        cfg_write(REG_BASE, 0);
        cfg_write(REG_TBYTES, 32);
        for (int t = 0; t < 4; t++)
            for (int i = 0; i < 8; i++)
                send_byte(i == 4 ? 8'(t == 3 ? 8 : t) : 8'($urandom), i == 0 && t == 0);
        drain();

        // Directed: record limit at the first byte with none left, then a bad size
        cfg_write(REG_MAXREC, 0);
        send_byte(8'h01, 1'b1);
        drain();
        cfg_write(REG_MAXREC, 24'hFF_FFFF);
        cfg_write(REG_TBYTES, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);   // not divisible: bad size
        drain();

        // Long receiver hold-off while the sender keeps offering
        cfg_write(REG_TBYTES, 8 * 20);
        sink_hold = 1;
        send_table(20, 1);
        drain();

        // Random phases across formats, architectures and sizes
        while (n_sent < 850) begin
            logic [2:0] f;
            int ne, eff;
            f = 3'($urandom);
            cfg_write(REG_FORMAT, f);
            cfg_write(REG_ARCH, 3'($urandom));
            case ($urandom_range(0, 5))
                0: cfg_write(REG_ESIZE, 8'd255);
                1: cfg_write(REG_ESIZE, 8'($urandom_range(0, 30)));
                default: cfg_write(REG_ESIZE, 0);
            endcase
            eff = esize_q != 0 ? esize_q : min_entry(fmt_q);
            ne = eff > 40 ? 1 : $urandom_range(1, 5);
            case ($urandom_range(0, 7))
                0: cfg_write(REG_TBYTES, 32'($urandom_range(0, 40)));
                default: cfg_write(REG_TBYTES, 32'(eff * ne));
            endcase
            case ($urandom_range(0, 3))
                0: cfg_write(REG_BASE, {$urandom, $urandom});
                1: cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FF00);
                default: cfg_write(REG_BASE, 64'($urandom));
            endcase
            cfg_write(REG_MAXREC, $urandom_range(0, 9) == 0 ?
                      24'(emitted + $urandom_range(0, 4)) : 24'hFF_FFFF);
            cfg_write(REG_SECTION, 16'($urandom));
            send_table(ne, $urandom_range(0, 5) != 0);
            if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), 1'b0);
            drain();
        end

        drain();
        if (errors == 0 && reloc_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/erd_pkg.sv
sv/erd_front.sv
sv/erd_queue.sv
sv/erd_back.sv
sv/elf_relocation_decoder_top.sv
tb/tb_top.sv
